/* rtl/fdsa_pkg.sv */
// ----------------------------------------------------------------------------
// fdsa_pkg
// Shared constants, codes and helpers of the file directory sector allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package fdsa_pkg;
  localparam int DIR_ENTRIES  = 32;
  localparam int SECTOR_TOTAL = 512;
  localparam int NAME_BYTES   = 8;

  localparam int SLOT_W  = $clog2(DIR_ENTRIES);
  localparam int SECT_W  = $clog2(SECTOR_TOTAL);
  localparam int NAME_W  = 64;
  localparam int START_W = 9;
  localparam int LEN_W   = 8;
  localparam int RSV_W   = 10;
  localparam int DIR_W   = NAME_W + START_W + LEN_W;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_CREATE = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_DISK_FULL = 3'd3;
  localparam logic [2:0] ST_DIR_FULL  = 3'd4;

  localparam logic [2:0] REG_RESERVED = 3'd0;

  // Keep the bytes up to the first zero byte and clear the rest.
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              live;
    res  = '0;
    live = 1'b1;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'h00) live = 1'b0;
      if (live) res[8*i +: 8] = raw[8*i +: 8];
    end
    return res;
  endfunction
endpackage
`default_nettype wire

/* rtl/fdsa_ram.sv */
// ----------------------------------------------------------------------------
// fdsa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module fdsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/file_directory_sector_allocator.sv */
// ----------------------------------------------------------------------------
// file_directory_sector_allocator
// Directory of named files with contiguous first-fit sector allocation.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   func, file_name, request_count
// out       output     out_valid/out_stall status, start_sector, sector_count
// cfg       input      APB psel/penable    paddr, pwdata, prdata
//
// One item at a time. Lookup and delete read the directory slot by slot, in
// a read state and a check state per slot; delete then frees the sectors one
// by one. Create scans the slots the same way, then reads the used map one bit
// at a time, then marks each allocated sector. The used map has one read port.
// After reset a clearing pass sweeps every sector of the used map; no item is
// taken meanwhile. A stalled result holds; the next item's result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none
module file_directory_sector_allocator
  import fdsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        func,
  input  wire logic [NAME_W-1:0] file_name,
  input  wire logic [7:0]        request_count,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [START_W-1:0]     start_sector,
  output logic [LEN_W-1:0]       sector_count,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DRD, S_DCHK, S_MSCAN, S_FILL, S_DWR, S_FREE, S_DONE
  } state_t;

  state_t                 state;
  logic [RSV_W-1:0]       reserved;
  logic [1:0]             op;
  logic [NAME_W-1:0]      name;
  logic [LEN_W-1:0]       want;
  logic [SLOT_W-1:0]      slot;
  logic [DIR_ENTRIES-1:0] slot_valid;
  logic [SECT_W:0]        j;
  logic                   pend_v;
  logic [SECT_W-1:0]      pend_j;
  logic [LEN_W-1:0]       run;
  logic [SECT_W:0]        k;
  logic [SECT_W:0]        kend;
  logic [START_W-1:0]     found_start;
  logic [2:0]             res_status;
  logic [START_W-1:0]     res_start;
  logic [LEN_W-1:0]       res_len;

  logic                   map_we;
  logic [SECT_W-1:0]      map_waddr;
  logic                   map_wdata;
  logic                   map_rdata;
  logic                   dir_we;
  logic [DIR_W-1:0]       dir_rdata;
  logic [NAME_W-1:0]      in_canon;
  logic                   sect_free;
  logic [SECT_W:0]        run_start;
  logic                   out_free;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_RESERVED) ? {{(32-RSV_W){1'b0}}, reserved} : 32'd0;
  assign in_stall = (state != S_IDLE);
  assign in_canon = canon_name(file_name);
  assign out_free = !out_valid || !out_stall;

  // A sector below the reserved limit always counts as used.
  assign sect_free = ({1'b0, pend_j} >= reserved) && !map_rdata;
  assign run_start = {1'b0, pend_j} + (SECT_W+1)'(1) - (SECT_W+1)'(want);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = k[SECT_W-1:0];
    map_wdata = 1'b0;
    case (state)
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = j[SECT_W-1:0];
      end
      S_FILL: begin
        map_we    = 1'b1;
        map_wdata = 1'b1;
      end
      S_FREE: map_we = (k < kend) && (k < (SECT_W+1)'(SECTOR_TOTAL));
      default: ;
    endcase
  end

  assign dir_we = (state == S_DWR);

  fdsa_ram #(.WIDTH(1), .DEPTH(SECTOR_TOTAL)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(j[SECT_W-1:0]), .rdata(map_rdata)
  );

  fdsa_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir (
    .clk(clk), .we(dir_we), .waddr(slot), .wdata({name, found_start, want}),
    .raddr(slot), .rdata(dir_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      reserved   <= '0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
      j          <= '0;
      pend_v     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_RESERVED)
        reserved <= pwdata[RSV_W-1:0];
      // The done state issues the next result itself when the slot frees up.
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          j <= j + 1'b1;
          if (j == (SECT_W+1)'(SECTOR_TOTAL-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op   <= func;
            name <= in_canon;
            want <= request_count;
            slot <= '0;
            if (in_canon[7:0] == 8'h00 || func == 2'd3) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else begin
              state <= S_DRD;
            end
          end
        end
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          state <= S_DONE;
          if (op == FUNC_CREATE) begin
            if (!slot_valid[slot]) begin
              if (want == '0) begin
                res_status <= ST_DISK_FULL;
              end else begin
                j      <= '0;
                pend_v <= 1'b0;
                run    <= '0;
                state  <= S_MSCAN;
              end
            end else if (dir_rdata[DIR_W-1 -: NAME_W] == name) begin
              res_status <= ST_EXISTS;
            end else if (slot == SLOT_W'(DIR_ENTRIES-1)) begin
              res_status <= ST_DIR_FULL;
            end else begin
              slot  <= slot + 1'b1;
              state <= S_DRD;
            end
          end else if (slot_valid[slot] && dir_rdata[DIR_W-1 -: NAME_W] == name) begin
            res_status <= ST_OK;
            res_start  <= dir_rdata[LEN_W +: START_W];
            res_len    <= dir_rdata[LEN_W-1:0];
            k          <= (SECT_W+1)'(dir_rdata[LEN_W +: START_W]);
            kend       <= (SECT_W+1)'(dir_rdata[LEN_W +: START_W])
                          + (SECT_W+1)'(dir_rdata[LEN_W-1:0]);
            if (op == FUNC_DELETE) state <= S_FREE;
          end else if (slot == SLOT_W'(DIR_ENTRIES-1)) begin
            res_status <= ST_NOT_FOUND;
          end else begin
            slot  <= slot + 1'b1;
            state <= S_DRD;
          end
        end
        S_MSCAN: begin
          // Reads run one bit ahead of the check of the previous bit.
          pend_v <= (j < (SECT_W+1)'(SECTOR_TOTAL));
          pend_j <= j[SECT_W-1:0];
          j      <= j + 1'b1;
          if (pend_v) begin
            if (sect_free && ({1'b0, run} + 9'd1) == {1'b0, want}) begin
              found_start <= START_W'(run_start);
              k           <= run_start;
              kend        <= run_start + (SECT_W+1)'(want);
              state       <= S_FILL;
            end else begin
              run <= sect_free ? run + 1'b1 : '0;
              if (pend_j == SECT_W'(SECTOR_TOTAL-1)) begin
                res_status <= ST_DISK_FULL;
                state      <= S_DONE;
              end
            end
          end
        end
        S_FILL: begin
          k <= k + 1'b1;
          if (k + 1'b1 == kend) state <= S_DWR;
        end
        S_DWR: begin
          slot_valid[slot] <= 1'b1;
          res_status       <= ST_OK;
          res_start        <= found_start;
          res_len          <= want;
          state            <= S_DONE;
        end
        S_FREE: begin
          if (map_we) begin
            k <= k + 1'b1;
          end else begin
            slot_valid[slot] <= 1'b0;
            state            <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            start_sector <= (res_status == ST_OK) ? res_start : '0;
            sector_count <= (res_status == ST_OK) ? res_len : '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/fdsa_checker.sv */
// ----------------------------------------------------------------------------
// fdsa_checker
// Port-level checks of the file directory sector allocator.
// ----------------------------------------------------------------------------
`default_nettype none
module fdsa_checker
  import fdsa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [2:0]         status,
  input wire logic [START_W-1:0] start_sector,
  input wire logic [LEN_W-1:0]   sector_count
);
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> start_sector == '0 && sector_count == '0)
    else $error("failed item carries a sector range");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_DIR_FULL)
    else $error("status code out of range");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> sector_count != '0)
    else $error("successful item with zero sectors");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");
endmodule

bind file_directory_sector_allocator fdsa_checker u_fdsa_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .status(status), .start_sector(start_sector), .sector_count(sector_count)
);
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// File directory sector allocator testbench
// Drives lookup, create, delete and unknown requests into the allocator, keeps a
// shadow directory and sector map to predict every answer, and compares the
// answers field by field. The reserved-sector register is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import fdsa_pkg::*;

  typedef struct packed {
    logic [1:0]        func;
    logic [NAME_W-1:0] name;
    logic [7:0]        count;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   count;
  } answer_t;

  localparam int IDLE_LIMIT = 20000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        func;
  logic [NAME_W-1:0] file_name;
  logic [7:0]        request_count;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        status;
  logic [START_W-1:0] start_sector;
  logic [LEN_W-1:0]  sector_count;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  file_directory_sector_allocator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .file_name(file_name), .request_count(request_count),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .start_sector(start_sector), .sector_count(sector_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow state of the allocator.
  logic                sect_used [SECTOR_TOTAL];
  logic [NAME_W-1:0]   dir_name [DIR_ENTRIES];
  logic [START_W-1:0]  dir_start [DIR_ENTRIES];
  logic [LEN_W-1:0]    dir_len [DIR_ENTRIES];
  int unsigned         rsv_limit;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       n_errors;
  int       n_sent;
  int       n_answers;
  int       n_ok_creates;
  int       idle_cycles;
  bit       quiet_tail;
  int       hold_cycles;
  bit       in_taken;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    res = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'h00) break;
      res[8*i +: 8] = raw[8*i +: 8];
    end
    return res;
  endfunction

  function automatic answer_t allocate(input logic [NAME_W-1:0] nm, input int want);
    answer_t a;
    int      run;
    a = '{ST_DIR_FULL, '0, '0};
    for (int s = 0; s < DIR_ENTRIES; s++) begin
      if (dir_name[s][7:0] == 8'h00) begin
        a.status = ST_DISK_FULL;
        if (want == 0) return a;
        run = 0;
        for (int j = 0; j < SECTOR_TOTAL; j++) begin
          if (j < rsv_limit || sect_used[j]) run = 0;
          else run++;
          if (run == want) begin
            for (int k = j + 1 - want; k <= j; k++) sect_used[k] = 1'b1;
            dir_name[s]  = nm;
            dir_start[s] = START_W'(j + 1 - want);
            dir_len[s]   = LEN_W'(want);
            n_ok_creates++;
            return '{ST_OK, START_W'(j + 1 - want), LEN_W'(want)};
          end
        end
        return a;
      end
      if (dir_name[s] == nm) begin
        a.status = ST_EXISTS;
        return a;
      end
    end
    return a;
  endfunction

  function automatic answer_t predict_answer(input request_t r);
    logic [NAME_W-1:0] nm;
    answer_t           a;
    int                hit;
    int                stop;
    nm  = trim_name(r.name);
    a   = '{ST_NOT_FOUND, '0, '0};
    hit = -1;
    if (nm[7:0] == 8'h00 || r.func == 2'd3) return a;
    if (r.func == FUNC_CREATE) return allocate(nm, r.count);
    for (int s = 0; s < DIR_ENTRIES; s++)
      if (hit < 0 && dir_name[s][7:0] != 8'h00 && dir_name[s] == nm) hit = s;
    if (hit < 0) return a;
    a = '{ST_OK, dir_start[hit], dir_len[hit]};
    if (r.func == FUNC_DELETE) begin
      stop = dir_start[hit] + dir_len[hit];
      for (int k = dir_start[hit]; k < stop && k < SECTOR_TOTAL; k++)
        sect_used[k] = 1'b0;
      dir_name[hit] = '0;
    end
    return a;
  endfunction

  // Driver: random bursts of idle time on the request side. A new item is
  // offered only once the previous one was taken at the last rising edge.
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid      <= 1'b1;
        func          <= pending_reqs[0].func;
        file_name     <= pending_reqs[0].name;
        request_count <= pending_reqs[0].count;
        void'(pending_reqs.pop_front());
        if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off while requests keep coming.
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on accepted requests, compare accepted answers.
  always @(posedge clk) begin
    answer_t exp_a;
    in_taken = in_valid && !in_stall;
    if (!rst) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        expected_answers.push_back(predict_answer('{func, file_name, request_count}));
        n_sent++;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        n_answers++;
        if (expected_answers.size() == 0) begin
          $error("answer with nothing expected: status %0d", status);
          n_errors++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (status !== exp_a.status) begin
            $error("status: expected %0d, actual %0d", exp_a.status, status);
            n_errors++;
          end
          if (start_sector !== exp_a.start) begin
            $error("start_sector: expected %0d, actual %0d", exp_a.start, start_sector);
            n_errors++;
          end
          if (sector_count !== exp_a.count) begin
            $error("sector_count: expected %0d, actual %0d", exp_a.count, sector_count);
            n_errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Names come from a small pool so that lookups and deletes find files.
  function automatic logic [NAME_W-1:0] pool_name(input int idx);
    logic [NAME_W-1:0] nm;
    nm = {8'(idx * 37 + 5), 8'h7a, 8'(idx + 3), 8'h41, 8'(idx * 11 + 1),
          8'h66, 8'h6c, 8'h30 + 8'(idx % 40) + 8'd1};
    return nm;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    r.func  = (pick < 45) ? FUNC_CREATE : (pick < 70) ? FUNC_DELETE :
              (pick < 95) ? FUNC_LOOKUP : 2'd3;
    r.name  = pool_name($urandom_range(0, 47));
    case ($urandom_range(0, 9))
      0: r.name = {$urandom, $urandom};
      1: r.name[8*$urandom_range(1, 7) +: 8] = 8'h00;
      2: r.name[7:0] = 8'h00;
      default: ;
    endcase
    r.count = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
    return r;
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic set_reserved(input int value);
    drain();
    apb_write(REG_RESERVED << 2, 32'(value));
    rsv_limit = value;
  endtask

  initial begin
    request_t r;
    int       rsv_set[6];
    rsv_set = '{0, 512, 17, 500, 3, 0};
    rst = 1'b1;
    in_valid = 1'b0;
    in_taken = 1'b0;
    out_stall = 1'b0;
    func = '0;
    file_name = '0;
    request_count = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    n_errors = 0;
    n_sent = 0;
    n_answers = 0;
    n_ok_creates = 0;
    idle_cycles = 0;
    quiet_tail = 1'b0;
    hold_cycles = 0;
    rsv_limit = 0;
    for (int i = 0; i < SECTOR_TOTAL; i++) sect_used[i] = 1'b0;
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      dir_name[i] = '0;
      dir_start[i] = '0;
      dir_len[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, empty name, zero request,
    // disk full, unknown operation, duplicates and a full directory.
    pending_reqs.push_back('{FUNC_CREATE, 64'hffff_ffff_ffff_ffff, 8'd255});
    pending_reqs.push_back('{FUNC_CREATE, 64'h0000_0000_0000_0041, 8'd0});
    pending_reqs.push_back('{FUNC_CREATE, 64'h0000_0000_0000_0041, 8'd1});
    pending_reqs.push_back('{FUNC_CREATE, 64'hdead_0000_0000_0041, 8'd2});
    pending_reqs.push_back('{FUNC_LOOKUP, 64'h1234_5600_0000_0041, 8'd0});
    pending_reqs.push_back('{FUNC_LOOKUP, 64'hffff_ffff_ffff_ffff, 8'd0});
    pending_reqs.push_back('{FUNC_CREATE, 64'hffff_ffff_ffff_ff00, 8'd5});
    pending_reqs.push_back('{FUNC_LOOKUP, 64'h0, 8'd0});
    pending_reqs.push_back('{2'd3, 64'h0000_0000_0000_0041, 8'd9});
    pending_reqs.push_back('{FUNC_CREATE, 64'h0000_0000_0000_0042, 8'd255});
    pending_reqs.push_back('{FUNC_CREATE, 64'h0000_0000_0000_0043, 8'd200});
    pending_reqs.push_back('{FUNC_DELETE, 64'h0000_0000_0000_0041, 8'd0});
    pending_reqs.push_back('{FUNC_DELETE, 64'h0000_0000_0000_0041, 8'd0});
    pending_reqs.push_back('{FUNC_DELETE, 64'hffff_ffff_ffff_ffff, 8'd0});
    // A name listed after the first empty slot is not seen by create.
    pending_reqs.push_back('{FUNC_CREATE, 64'h0000_0000_0000_0042, 8'd1});
    for (int i = 0; i < DIR_ENTRIES + 2; i++)
      pending_reqs.push_back('{FUNC_CREATE, 64'h0000_0000_0000_5000 + 64'(i), 8'd1});
    for (int i = 0; i < DIR_ENTRIES; i++)
      pending_reqs.push_back('{FUNC_DELETE, 64'h0000_0000_0000_5000 + 64'(i), 8'd0});
    pending_reqs.push_back('{FUNC_DELETE, 64'h0000_0000_0000_0042, 8'd0});
    pending_reqs.push_back('{FUNC_DELETE, 64'h0000_0000_0000_0043, 8'd0});
    pending_reqs.push_back('{FUNC_DELETE, 64'hffff_ffff_ffff_ffff, 8'd0});

    // Random phases, each with its own reserved-sector setting.
    foreach (rsv_set[p]) begin
      set_reserved(rsv_set[p]);
      if (p == 5) quiet_tail = 1'b1;
      for (int i = 0; i < 170; i++) begin
        r = random_request();
        pending_reqs.push_back(r);
      end
      if (p == 2) begin
        while (pending_reqs.size() > 150) @(posedge clk);
        hold_cycles = 3000;
      end
    end
    drain();
    $display("covered %0d requests, %0d answers, %0d successful creates",
             n_sent, n_answers, n_ok_creates);
    $display("reserved sectors swept over 0, 3, 17, 500 and 512");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* file_directory_sector_allocator.f */
rtl/fdsa_pkg.sv
rtl/fdsa_ram.sv
rtl/file_directory_sector_allocator.sv
rtl/fdsa_checker.sv
tb/sv/testbench.sv
